### sv/wsic_pkg.sv
// Package for the wavetable sound and IRQ counter unit.
// Holds shared widths, codes, region decodes and the divider handshake types.
// No dependencies.
package wsic_pkg;

    localparam int RamAw = 7;
    localparam int RamDepth = 1 << RamAw;
    localparam int DivNw = 10;
    localparam int DivDw = 9;

    localparam logic [3:0] UPDATE_PERIOD = 4'd15;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [15:0] REGION_MASK = 16'hF800;
    localparam logic [15:0] REG_RAM     = 16'h4800;
    localparam logic [15:0] REG_IRQ_LO  = 16'h5000;
    localparam logic [15:0] REG_IRQ_HI  = 16'h5800;
    localparam logic [15:0] REG_SOUND   = 16'hE000;
    localparam logic [15:0] REG_PTR     = 16'hF800;

    localparam logic [14:0] IRQ_TOP     = 15'h7FFF;
    localparam logic [6:0]  CHAN_BASE   = 7'h40;
    localparam logic [6:0]  CFG_ADDR    = 7'h7F;
    localparam logic [7:0]  LEN_MASK    = 8'hFC;

    typedef struct packed {
        logic             start;
        logic [DivNw-1:0] dividend;
        logic [DivDw-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DivNw-1:0] quot;
        logic [DivDw-1:0] rem;
    } t_div_rsp;

endpackage

### sv/wsic_if.sv
// Channel interfaces for the wavetable sound and IRQ counter unit.
// Depends on nothing; valid/ready handshake with payload.
interface wsic_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    modport source (output valid, action, address, write_data, input ready);
    modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface wsic_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        read_data;
    logic              irq_pending;
    logic              audio_updated;
    logic signed [7:0] audio_level;
    logic signed [8:0] audio_delta;
    modport source (output valid, read_data, irq_pending, audio_updated, audio_level,
                    audio_delta, input ready);
    modport sink   (input valid, read_data, irq_pending, audio_updated, audio_level,
                    audio_delta, output ready);
endinterface

### sv/wsic_ram.sv
// Generic single-port synchronous RAM, registered read data.
// No dependencies.
module wsic_ram #(
    parameter int AW = 7,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [1 << AW];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;
endmodule

### sv/wsic_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wsic_pkg.
module wsic_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsic_pkg::t_div_req i_req,
    output wsic_pkg::t_div_rsp o_rsp
);
    logic [wsic_pkg::DivNw-1:0] r_quo, n_quo;
    logic [wsic_pkg::DivDw-1:0] r_rem, n_rem, r_dsr;
    logic [3:0]                 r_cnt;
    logic                       r_busy, r_done;
    logic [wsic_pkg::DivDw:0]   w_t, w_d;

    always_comb begin
        w_t = {r_rem, r_quo[wsic_pkg::DivNw-1]};
        w_d = {1'b0, r_dsr};
        if (w_t >= w_d) begin
            n_rem = wsic_pkg::DivDw'(w_t - w_d);
            n_quo = {r_quo[wsic_pkg::DivNw-2:0], 1'b1};
        end else begin
            n_rem = w_t[wsic_pkg::DivDw-1:0];
            n_quo = {r_quo[wsic_pkg::DivNw-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(wsic_pkg::DivNw);
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule

### sv/wavetable_sound_and_irq_counter_unit.sv
// Top level of the wavetable sound and IRQ counter unit.
// Depends on wsic_pkg, wsic_if, wsic_ram and wsic_div.
//
// One transaction is a CPU tick, a register read or a register write. After reset a
// clearing pass zeroes all 128 words of the wave RAM, with no transaction taken. Writes,
// ticks without a channel step and counter reads are answered straight from S_IDLE, RAM
// reads after the registered read in S_RD. A tick that steps a channel is paced by the
// single RAM port (eight fetches, a sample read, three phase write-backs) and two divider
// runs (phase modulo and channel average). One transaction is in flight at a time.
module wavetable_sound_and_irq_counter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsic_in_if.sink   i_in,
    wsic_out_if.source o_out
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_MOD   = 4'd4;
    localparam logic [3:0] S_SMP   = 4'd5;
    localparam logic [3:0] S_WB    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_AVG   = 4'd8;

    logic [3:0]  r_state;
    logic [7:0]  r_cnt;
    logic [6:0]  r_ptr;
    logic        r_autoinc, r_irq_flag, r_off;
    logic [15:0] r_irq_cnt;
    logic [3:0]  r_tdiv;
    logic [2:0]  r_ch, r_nm1;
    logic signed [7:0] r_prev;
    logic [7:0]  r_lvl [8];
    logic [7:0]  r_b [8];
    logic [23:0] r_phase;
    logic        r_odd;
    logic        r_neg;

    logic        r_ov, r_upd;
    logic [7:0]  r_rd;
    logic signed [8:0] r_delta;

    logic        ram_we;
    logic [6:0]  ram_addr;
    logic [7:0]  ram_wd, ram_q;

    wsic_pkg::t_div_req div_req;
    wsic_pkg::t_div_rsp div_rsp;

    logic        w_acc;
    logic [15:0] w_region;
    logic [6:0]  w_base;
    logic [24:0] w_sum25;
    logic [8:0]  w_len;
    logic [7:0]  w_pos;
    logic [3:0]  w_smp;
    logic signed [4:0] w_sm8;
    logic signed [9:0] w_level;
    logic signed [10:0] w_tot;
    logic [10:0] w_mag;
    logic signed [7:0] w_avg;
    logic [3:0]  n_tdiv;
    logic [15:0] n_irq;
    logic [14:0] w_inc;

    wsic_ram #(.AW(wsic_pkg::RamAw), .DW(8)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wd),
        .o_rdata(ram_q)
    );

    wsic_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE) && (!r_ov || o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_region   = i_in.address & wsic_pkg::REGION_MASK;
    assign w_base     = wsic_pkg::CHAN_BASE | {1'b0, r_ch, 3'b000};

    assign w_sum25 = 25'({r_b[5], r_b[3], r_b[1]}) + 25'({r_b[4][1:0], r_b[2], r_b[0]});
    assign w_len   = 9'd256 - 9'(r_b[4] & wsic_pkg::LEN_MASK);
    assign w_pos   = div_rsp.rem[7:0] + r_b[6];
    assign w_smp   = r_odd ? ram_q[7:4] : ram_q[3:0];
    assign w_sm8   = $signed({1'b0, w_smp}) - 5'sd8;
    assign w_level = w_sm8 * $signed({1'b0, r_b[7][3:0]});
    assign w_avg   = r_neg ? -$signed(div_rsp.quot[7:0]) : $signed(div_rsp.quot[7:0]);
    assign n_tdiv  = r_tdiv + 4'd1;
    assign w_inc   = r_irq_cnt[14:0] + 15'd1;

    always_comb begin
        w_tot = '0;
        for (int c = 0; c < 8; c++) begin
            if (3'(c) >= 3'd7 - r_nm1) begin
                w_tot = w_tot + 11'($signed(r_lvl[c]));
            end
        end
        w_mag = w_tot[10] ? 11'(-w_tot) : 11'(w_tot);
    end

    always_comb begin
        n_irq = r_irq_cnt;
        if (r_irq_cnt[15] && (r_irq_cnt[14:0] != wsic_pkg::IRQ_TOP)) begin
            n_irq = {1'b1, w_inc};
        end
    end

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = r_ptr;
        ram_wd   = i_in.write_data;
        div_req  = '0;
        case (r_state)
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = r_cnt[6:0];
                ram_wd   = '0;
            end
            S_IDLE: begin
                ram_we = w_acc && (i_in.action == wsic_pkg::ACT_WRITE)
                         && (w_region == wsic_pkg::REG_RAM);
            end
            S_FETCH: begin
                ram_addr = w_base | {4'd0, r_cnt[2:0]};
            end
            S_MOD: begin
                ram_addr = w_pos[7:1];
            end
            S_WB: begin
                ram_we = 1'b1;
                case (r_cnt[1:0])
                    2'd0: begin
                        ram_addr = w_base | 7'd5;
                        ram_wd   = r_phase[23:16];
                    end
                    2'd1: begin
                        ram_addr = w_base | 7'd3;
                        ram_wd   = r_phase[15:8];
                    end
                    default: begin
                        ram_addr = w_base | 7'd1;
                        ram_wd   = r_phase[7:0];
                    end
                endcase
            end
            S_SUM: begin
                div_req.start    = 1'b1;
                div_req.dividend = w_mag[9:0];
                div_req.divisor  = 9'(r_nm1) + 9'd1;
            end
            default: begin
            end
        endcase
        if (r_state == S_FETCH && r_cnt == 8'd8) begin
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, w_sum25[24:16]};
            div_req.divisor  = w_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_ptr      <= '0;
            r_autoinc  <= 1'b0;
            r_irq_flag <= 1'b0;
            r_off      <= 1'b0;
            r_irq_cnt  <= '0;
            r_tdiv     <= '0;
            r_ch       <= 3'd7;
            r_nm1      <= '0;
            r_prev     <= '0;
            r_ov       <= 1'b0;
            for (int c = 0; c < 8; c++) begin
                r_lvl[c] <= '0;
            end
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'(wsic_pkg::RamDepth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_rd    <= '0;
                        r_upd   <= 1'b0;
                        r_delta <= '0;
                        r_ov    <= 1'b1;
                        case (i_in.action)
                            wsic_pkg::ACT_TICK: begin
                                r_irq_cnt <= n_irq;
                                if (n_irq != r_irq_cnt && n_irq[14:0] == wsic_pkg::IRQ_TOP) begin
                                    r_irq_flag <= 1'b1;
                                end
                                if (!r_off) begin
                                    r_tdiv <= n_tdiv;
                                    if (n_tdiv == wsic_pkg::UPDATE_PERIOD) begin
                                        r_tdiv  <= '0;
                                        r_ov    <= 1'b0;
                                        r_cnt   <= '0;
                                        r_state <= S_FETCH;
                                    end
                                end
                            end
                            wsic_pkg::ACT_READ: begin
                                if (w_region == wsic_pkg::REG_RAM) begin
                                    r_ov    <= 1'b0;
                                    r_state <= S_RD;
                                    if (r_autoinc) begin
                                        r_ptr <= r_ptr + 7'd1;
                                    end
                                end else if (w_region == wsic_pkg::REG_IRQ_LO) begin
                                    r_rd <= r_irq_cnt[7:0];
                                end else if (w_region == wsic_pkg::REG_IRQ_HI) begin
                                    r_rd <= r_irq_cnt[15:8];
                                end
                            end
                            wsic_pkg::ACT_WRITE: begin
                                if (w_region == wsic_pkg::REG_RAM) begin
                                    if (r_ptr == wsic_pkg::CFG_ADDR) begin
                                        r_nm1 <= i_in.write_data[6:4];
                                    end
                                    if (r_autoinc) begin
                                        r_ptr <= r_ptr + 7'd1;
                                    end
                                end else if (w_region == wsic_pkg::REG_IRQ_LO) begin
                                    r_irq_cnt[7:0] <= i_in.write_data;
                                    r_irq_flag     <= 1'b0;
                                end else if (w_region == wsic_pkg::REG_IRQ_HI) begin
                                    r_irq_cnt[15:8] <= i_in.write_data;
                                    r_irq_flag      <= 1'b0;
                                end else if (w_region == wsic_pkg::REG_SOUND) begin
                                    r_off <= i_in.write_data[6];
                                end else if (w_region == wsic_pkg::REG_PTR) begin
                                    r_ptr     <= i_in.write_data[6:0];
                                    r_autoinc <= i_in.write_data[7];
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_rd    <= ram_q;
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FETCH: begin
                    if (r_cnt != 8'd0) begin
                        r_b[r_cnt[2:0] - 3'd1] <= ram_q;
                    end
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'd8) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (div_rsp.done) begin
                        r_phase <= {div_rsp.rem[7:0], w_sum25[15:0]};
                        r_odd   <= w_pos[0];
                        r_state <= S_SMP;
                    end
                end
                S_SMP: begin
                    r_lvl[r_ch] <= w_level[7:0];
                    r_cnt   <= '0;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt == 8'd2) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_neg   <= w_tot[10];
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (div_rsp.done) begin
                        r_delta <= 9'(w_avg) - 9'(r_prev);
                        r_prev  <= w_avg;
                        r_upd   <= 1'b1;
                        r_ov    <= 1'b1;
                        if (r_ch <= 3'd7 - r_nm1) begin
                            r_ch <= 3'd7;
                        end else begin
                            r_ch <= r_ch - 3'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.read_data     = r_rd;
    assign o_out.irq_pending   = r_irq_flag;
    assign o_out.audio_updated = r_upd;
    assign o_out.audio_level   = r_prev;
    assign o_out.audio_delta   = r_delta;
endmodule
